// ===== src/lcr_pkg.sv =====
// Shared types, constants and reply tables for the lens command responder.
package lcr_pkg;

  // Reply kinds held in the transmit queue state.
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_ZERO  = 3'd1;
  localparam logic [2:0] KIND_SHORT = 3'd2;
  localparam logic [2:0] KIND_SUM   = 3'd3;
  localparam logic [2:0] KIND_LONG  = 3'd4;
  localparam logic [2:0] KIND_DUMP  = 3'd5;

  // Known command words.
  localparam logic [31:0] CMD_ZERO  = 32'h0000_f2b0;
  localparam logic [31:0] CMD_SHORT = 32'h0000_f6c0;
  localparam logic [31:0] CMD_SYNC  = 32'h0001_f5a0;
  localparam logic [31:0] CMD_LONG  = 32'h0000_f9c1;
  localparam logic [31:0] CMD_DUMP  = 32'h0000_f0c3;

  // Dump header bytes.
  localparam logic [7:0] DUMP_HDR0 = 8'hBF;
  localparam logic [7:0] DUMP_HDR1 = 8'h08;

  // Table lengths and the reply position width.
  localparam int unsigned SHORT_LEN = 5;
  localparam int unsigned LONG_LEN  = 21;
  localparam int unsigned POS_W     = 12;

  // Default zero dump length.
  localparam int unsigned DUMP_LENGTH_DEF = 2239;

  // Input transaction payload.
  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } lcr_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       last;
    logic       cmd_done;
    logic       cmd_unknown;
  } lcr_out_t;

  // Body of the short reply table.
  function automatic logic [7:0] short_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h00;
      3'd1:    b = 8'h0a;
      3'd2:    b = 8'h10;
      3'd3:    b = 8'hc4;
      3'd4:    b = 8'h09;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Body of the long info table.
  function automatic logic [7:0] long_byte(input logic [4:0] idx);
    logic [7:0] b;
    unique case (idx)
      5'd3:    b = 8'h01;
      5'd4:    b = 8'h10;
      5'd7:    b = 8'h41;
      5'd8:    b = 8'h41;
      5'd9:    b = 8'h41;
      5'd10:   b = 8'h32;
      5'd11:   b = 8'h34;
      5'd12:   b = 8'h33;
      5'd13:   b = 8'h38;
      5'd14:   b = 8'h34;
      5'd15:   b = 8'h31;
      5'd19:   b = 8'h01;
      5'd20:   b = 8'h11;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== src/lens_command_responder.sv =====
// Lens command responder: collects four-byte commands and serves canned replies.
// Each result is registered and appears on out_valid in the cycle after its input transaction.
// Throughput: one transaction per cycle; the output register takes a new result
// whenever it is empty or its result is taken in the same cycle.
// Reset (rst_n low, synchronous) clears the command collector, the transmit
// queue and the output valid flag.
module lens_command_responder #(
  parameter int unsigned DUMP_LENGTH = lcr_pkg::DUMP_LENGTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lcr_pkg::lcr_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lcr_pkg::lcr_out_t out_data
);
  import lcr_pkg::*;

  localparam logic [POS_W-1:0] DUMP_TOTAL = POS_W'(DUMP_LENGTH + 3);
  localparam logic [POS_W-1:0] SHORT_END  = POS_W'(SHORT_LEN + 2);
  localparam logic [POS_W-1:0] LONG_END   = POS_W'(LONG_LEN + 2);

  logic [1:0]       rx_count_r, rx_count_nxt;
  logic [7:0]       rx_sum_r, rx_sum_nxt;
  logic [31:0]      cmd_word_r, cmd_word_nxt;
  logic [2:0]       reply_kind_r, reply_kind_nxt;
  logic [POS_W-1:0] reply_pos_r, reply_pos_nxt;
  logic [7:0]       tx_sum_r, tx_sum_nxt;
  logic             out_valid_r;
  lcr_out_t         out_data_r, res;

  logic             in_fire;
  logic [7:0]       rx_sum_add;
  logic [POS_W-1:0] reply_len;
  logic [POS_W-1:0] tab_idx;
  logic [POS_W:0]   pos_inc;
  logic [7:0]       tab_b;
  logic             is_table;
  logic [POS_W-1:0] tab_end;

  // The output register frees up when empty or when its transaction completes.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Total reply length per kind, command-sum byte included.
  always_comb begin
    unique case (reply_kind_r)
      KIND_ZERO:  reply_len = POS_W'(2);
      KIND_SHORT: reply_len = POS_W'(SHORT_LEN + 3);
      KIND_SUM:   reply_len = POS_W'(1);
      KIND_LONG:  reply_len = POS_W'(LONG_LEN + 3);
      KIND_DUMP:  reply_len = DUMP_TOTAL;
      default:    reply_len = '0;
    endcase
  end

  // Table lookup for the short and long replies.
  assign tab_idx  = reply_pos_r - POS_W'(2);
  assign is_table = (reply_kind_r == KIND_SHORT) || (reply_kind_r == KIND_LONG);
  assign tab_end  = (reply_kind_r == KIND_SHORT) ? SHORT_END : LONG_END;
  assign tab_b    = (reply_kind_r == KIND_SHORT) ? short_byte(tab_idx[2:0])
                                                 : long_byte(tab_idx[4:0]);
  assign pos_inc  = {1'b0, reply_pos_r} + {{POS_W{1'b0}}, 1'b1};
  assign rx_sum_add = rx_sum_r + in_data.rx_byte;

  // Next state and result for one transaction.
  always_comb begin
    rx_count_nxt   = rx_count_r;
    rx_sum_nxt     = rx_sum_r;
    cmd_word_nxt   = cmd_word_r;
    reply_kind_nxt = reply_kind_r;
    reply_pos_nxt  = reply_pos_r;
    tx_sum_nxt     = tx_sum_r;
    res            = '0;
    if (!in_data.command) begin
      // Received byte: place it in the command word and add it to the sum.
      cmd_word_nxt[{rx_count_r, 3'b000} +: 8] = in_data.rx_byte;
      if (rx_count_r == 2'd3) begin
        res.cmd_done = 1'b1;
        unique case (cmd_word_nxt)
          CMD_ZERO:  reply_kind_nxt = KIND_ZERO;
          CMD_SHORT: reply_kind_nxt = KIND_SHORT;
          CMD_SYNC:  reply_kind_nxt = KIND_SUM;
          CMD_LONG:  reply_kind_nxt = KIND_LONG;
          CMD_DUMP:  reply_kind_nxt = KIND_DUMP;
          default: begin
            reply_kind_nxt  = KIND_SUM;
            res.cmd_unknown = 1'b1;
          end
        endcase
        reply_pos_nxt = '0;
        tx_sum_nxt    = rx_sum_add;
        rx_sum_nxt    = '0;
        rx_count_nxt  = 2'd0;
      end else begin
        rx_sum_nxt   = rx_sum_add;
        rx_count_nxt = rx_count_r + 2'd1;
      end
    end else if (reply_len != '0 && reply_pos_r < reply_len) begin
      // Transmit request with a byte queued.
      res.tx_valid = 1'b1;
      if (reply_pos_r == '0) begin
        res.tx_byte = tx_sum_r;
        tx_sum_nxt  = '0;
      end else if (is_table) begin
        if (reply_pos_r == POS_W'(1)) begin
          res.tx_byte = (reply_kind_r == KIND_SHORT) ? 8'(SHORT_LEN) : 8'(LONG_LEN);
        end else if (reply_pos_r < tab_end) begin
          res.tx_byte = tab_b;
          tx_sum_nxt  = tx_sum_r + tab_b;
        end else begin
          res.tx_byte = tx_sum_r;
        end
      end else if (reply_kind_r == KIND_DUMP) begin
        if (reply_pos_r == POS_W'(1)) begin
          res.tx_byte = DUMP_HDR0;
        end else if (reply_pos_r == POS_W'(2)) begin
          res.tx_byte = DUMP_HDR1;
        end else begin
          res.tx_byte = 8'h00;
        end
      end else begin
        res.tx_byte = 8'h00;
      end
      if (pos_inc >= {1'b0, reply_len}) begin
        res.last       = 1'b1;
        reply_kind_nxt = KIND_NONE;
        reply_pos_nxt  = '0;
      end else begin
        reply_pos_nxt = pos_inc[POS_W-1:0];
      end
    end else begin
      // Transmit request with an empty queue.
      reply_kind_nxt = KIND_NONE;
      reply_pos_nxt  = '0;
    end
  end

  // State and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_count_r   <= '0;
      rx_sum_r     <= '0;
      cmd_word_r   <= '0;
      reply_kind_r <= KIND_NONE;
      reply_pos_r  <= '0;
      tx_sum_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        rx_count_r   <= rx_count_nxt;
        rx_sum_r     <= rx_sum_nxt;
        cmd_word_r   <= cmd_word_nxt;
        reply_kind_r <= reply_kind_nxt;
        reply_pos_r  <= reply_pos_nxt;
        tx_sum_r     <= tx_sum_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res;
    end
  end

endmodule
